// File: hw/rtl/speed_ramp_timer_period_macros.svh
// Assertion macros for the speed ramp timer period block.
`ifndef SPEED_RAMP_TIMER_PERIOD_MACROS_SVH
`define SPEED_RAMP_TIMER_PERIOD_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SRTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SRTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/srtp_pkg.sv
// Types, constants and the microcode table of the speed ramp timer period block.
`default_nettype none

package srtp_pkg;

  localparam int unsigned SPD_W      = 32;
  localparam int unsigned ACC_W      = 31;
  localparam int unsigned RN_W       = 48;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned PRELOAD_W  = 16;
  localparam int unsigned POST_W     = 18;
  localparam int unsigned PMAG_W     = 17;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned PC_W       = 4;

  localparam logic [PRELOAD_W-1:0] TIMER_FULL = 16'hFFFF;
  localparam logic [CNT_W-1:0]     DIV1_LAST  = 6'd47;
  localparam logic [CNT_W-1:0]     DIV2_LAST  = 6'd31;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_NUM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd2;

  typedef logic [2:0]      op_t;
  typedef logic [2:0]      cond_t;
  typedef logic [PC_W-1:0] pc_t;

  localparam op_t OP_NOP   = 3'd0;
  localparam op_t OP_IDLE  = 3'd1;
  localparam op_t OP_RAMP  = 3'd2;
  localparam op_t OP_LOAD1 = 3'd3;
  localparam op_t OP_DIV   = 3'd4;
  localparam op_t OP_SPLIT = 3'd5;
  localparam op_t OP_BASE2 = 3'd6;
  localparam op_t OP_EMIT  = 3'd7;

  localparam cond_t COND_NEVER     = 3'd0;
  localparam cond_t COND_ALWAYS    = 3'd1;
  localparam cond_t COND_NOT_START = 3'd2;
  localparam cond_t COND_CUR_ZERO  = 3'd3;
  localparam cond_t COND_CNT_NZ    = 3'd4;
  localparam cond_t COND_Q_ZERO    = 3'd5;
  localparam cond_t COND_OUT_BUSY  = 3'd6;

  localparam pc_t STEP_IDLE  = 4'd0;
  localparam pc_t STEP_RAMP  = 4'd1;
  localparam pc_t STEP_LOAD1 = 4'd2;
  localparam pc_t STEP_DIV1  = 4'd3;
  localparam pc_t STEP_SPLIT = 4'd4;
  localparam pc_t STEP_DIV2  = 4'd5;
  localparam pc_t STEP_BASE2 = 4'd6;
  localparam pc_t STEP_EMIT  = 4'd7;
  localparam pc_t STEP_BACK  = 4'd8;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      STEP_IDLE:  w = '{op: OP_IDLE,  cond: COND_NOT_START, target: STEP_IDLE};
      STEP_RAMP:  w = '{op: OP_RAMP,  cond: COND_NEVER,     target: STEP_IDLE};
      STEP_LOAD1: w = '{op: OP_LOAD1, cond: COND_CUR_ZERO,  target: STEP_EMIT};
      STEP_DIV1:  w = '{op: OP_DIV,   cond: COND_CNT_NZ,    target: STEP_DIV1};
      STEP_SPLIT: w = '{op: OP_SPLIT, cond: COND_Q_ZERO,    target: STEP_EMIT};
      STEP_DIV2:  w = '{op: OP_DIV,   cond: COND_CNT_NZ,    target: STEP_DIV2};
      STEP_BASE2: w = '{op: OP_BASE2, cond: COND_NEVER,     target: STEP_IDLE};
      STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_BUSY,  target: STEP_EMIT};
      STEP_BACK:  w = '{op: OP_NOP,   cond: COND_ALWAYS,    target: STEP_IDLE};
      default:    w = '{op: OP_NOP,   cond: COND_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/srtp_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface srtp_in_if
  import srtp_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [SPD_W-1:0] speed_value;

  modport source (output valid, mode, speed_value, input ready);
  modport sink (input valid, mode, speed_value, output ready);
endinterface

interface srtp_out_if
  import srtp_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [PRELOAD_W-1:0]     timer_preload;
  logic signed [POST_W-1:0] postscaler;
  logic signed [SPD_W-1:0]  current_speed_out;

  modport source (output valid, timer_preload, postscaler, current_speed_out, input ready);
  modport sink (input valid, timer_preload, postscaler, current_speed_out, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/speed_ramp_timer_period.sv
// Stepper speed ramp that turns each ramp tick into a step-timer preload and postscaler.
//
// A set-target item is taken and gives no result. A ramp tick with the speed
// already at target is also taken with no result. Any other tick runs through
// a small microcoded sequencer: a tick that ends at zero speed goes from the
// load step straight to emit, a tick whose base stays below 65535 runs only the
// rate division, and one that needs the postscaler split runs both divisions.
// They share one restoring divider that retires one quotient bit per cycle: 48
// steps for the rate division and 32 for the postscaler division.
// The finished result sits in an output register, so the next item is taken
// while it waits for transfer; the sequencer holds only if a second result is
// ready before the first has been transferred.
`default_nettype none

`include "speed_ramp_timer_period_macros.svh"

module speed_ramp_timer_period
  import srtp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  srtp_in_if.sink                    in_if,
  srtp_out_if.source                 out_if
);

  pc_t                     pc_r, pc_nxt;
  logic signed [SPD_W-1:0] cur_r, cur_nxt;
  logic signed [SPD_W-1:0] tgt_r, tgt_nxt;
  logic [RN_W-1:0]         rn_r;
  logic [ACC_W-1:0]        acc_r;
  logic [ACC_W-1:0]        max_r;
  logic [RN_W-1:0]         dq_r;
  logic [SPD_W-1:0]        rem_r;
  logic [SPD_W-1:0]        dvs_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [SPD_W-1:0]        base_r;
  logic [PMAG_W-1:0]       pmag_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [PRELOAD_W-1:0]    preload_r;
  logic signed [POST_W-1:0] post_r;
  logic signed [SPD_W-1:0] speed_out_r;

  uword_t               uw;
  logic                 in_fire;
  logic                 start;
  logic                 take;
  logic                 out_busy;
  logic                 emit_load;
  logic                 cur_zero;
  logic [SPD_W-1:0]     cur_mag;
  logic [SPD_W:0]       rem_sh;
  logic [SPD_W:0]       rem_sub;
  logic                 ge;
  logic [SPD_W-1:0]     rem_new;
  logic [SPD_W-1:0]     base_sat;
  logic [PMAG_W-1:0]    rsum;
  logic [PMAG_W-1:0]    q;
  logic [PMAG_W-1:0]    q_inc;
  logic signed [SPD_W:0] diff;
  logic [SPD_W:0]       dmag;
  logic signed [SPD_W-1:0] cur_ramp;
  logic [SPD_W-1:0]     req_mag;
  logic signed [SPD_W-1:0] max_s;
  logic signed [SPD_W-1:0] tgt_clamp;
  logic [PRELOAD_W-1:0] preload_val;
  logic signed [POST_W-1:0] post_val;

  always_comb begin
    uw        = ucode(pc_r);
    in_fire   = in_if.valid && in_if.ready;
    start     = in_fire && in_if.mode && (cur_r != tgt_r);
    out_busy  = out_valid_r && !out_if.ready;
    emit_load = (uw.op == OP_EMIT) && !out_busy;
    cur_zero  = (cur_r == '0);
    cur_mag   = cur_r[SPD_W-1] ? (SPD_W'(0) - cur_r) : cur_r;

    rem_sh  = {rem_r, dq_r[RN_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
    rem_new = ge ? rem_sub[SPD_W-1:0] : rem_sh[SPD_W-1:0];

    base_sat = (|dq_r[RN_W-1:SPD_W]) ? '1 : dq_r[SPD_W-1:0];
    rsum     = {1'b0, base_sat[SPD_W-1:PRELOAD_W]} + {1'b0, base_sat[PRELOAD_W-1:0]};
    q        = {1'b0, base_sat[SPD_W-1:PRELOAD_W]}
             + PMAG_W'(rsum >= {1'b0, TIMER_FULL})
             + PMAG_W'(rsum >= {TIMER_FULL, 1'b0});
    q_inc    = q + PMAG_W'(1);

    diff     = {tgt_r[SPD_W-1], tgt_r} - {cur_r[SPD_W-1], cur_r};
    dmag     = diff[SPD_W] ? ((SPD_W+1)'(0) - diff) : diff;
    if (dmag < {2'b00, acc_r}) begin
      cur_ramp = tgt_r;
    end else if (diff > 0) begin
      cur_ramp = cur_r + {1'b0, acc_r};
    end else begin
      cur_ramp = cur_r - {1'b0, acc_r};
    end

    req_mag   = in_if.speed_value[SPD_W-1] ? (SPD_W'(0) - in_if.speed_value)
                                           : in_if.speed_value;
    max_s     = {1'b0, max_r};
    if (req_mag > {1'b0, max_r}) begin
      tgt_clamp = in_if.speed_value[SPD_W-1] ? (SPD_W'(0) - max_s) : max_s;
    end else begin
      tgt_clamp = in_if.speed_value;
    end

    if (cur_zero) begin
      preload_val = '0;
      post_val    = '0;
    end else begin
      preload_val = TIMER_FULL - base_r[PRELOAD_W-1:0];
      post_val    = cur_r[SPD_W-1] ? (POST_W'(0) - {1'b0, pmag_r}) : {1'b0, pmag_r};
    end

    case (uw.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NOT_START: take = !start;
      COND_CUR_ZERO:  take = cur_zero;
      COND_CNT_NZ:    take = (cnt_r != '0);
      COND_Q_ZERO:    take = (q == '0);
      COND_OUT_BUSY:  take = out_busy;
      default:        take = 1'b1;
    endcase
    pc_nxt = take ? uw.target : pc_r + pc_t'(1);

    cur_nxt = (uw.op == OP_RAMP) ? cur_ramp : cur_r;
    tgt_nxt = (in_fire && !in_if.mode) ? tgt_clamp : tgt_r;

    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_if.ready              = (uw.op == OP_IDLE);
  assign out_if.valid             = out_valid_r;
  assign out_if.timer_preload     = preload_r;
  assign out_if.postscaler        = post_r;
  assign out_if.current_speed_out = speed_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_IDLE;
      cur_r       <= '0;
      tgt_r       <= '0;
      out_valid_r <= 1'b0;
      rn_r        <= '0;
      acc_r       <= ACC_W'(1);
      max_r       <= '1;
    end else begin
      pc_r        <= pc_nxt;
      cur_r       <= cur_nxt;
      tgt_r       <= tgt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_RATE_NUM:  rn_r  <= cfg_data[RN_W-1:0];
          REG_ACCEL:     acc_r <= cfg_data[ACC_W-1:0];
          REG_MAX_SPEED: max_r <= cfg_data[ACC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LOAD1: begin
        dq_r  <= rn_r;
        rem_r <= '0;
        dvs_r <= cur_mag;
        cnt_r <= DIV1_LAST;
      end
      OP_DIV: begin
        dq_r  <= {dq_r[RN_W-2:0], ge};
        rem_r <= rem_new;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      OP_SPLIT: begin
        base_r <= base_sat;
        pmag_r <= q_inc;
        dq_r   <= {base_sat, {(RN_W-SPD_W){1'b0}}};
        rem_r  <= '0;
        dvs_r  <= {{(SPD_W-PMAG_W){1'b0}}, q_inc};
        cnt_r  <= DIV2_LAST;
      end
      OP_BASE2: begin
        base_r <= dq_r[SPD_W-1:0];
      end
      OP_EMIT: begin
        if (emit_load) begin
          preload_r   <= preload_val;
          post_r      <= post_val;
          speed_out_r <= cur_r;
        end
      end
      default: ;
    endcase
  end

  `SRTP_ASSERT_NXT(a_speed_moves_only_on_ramp, uw.op != OP_RAMP, $stable(cur_r), "speed changed outside a ramp step")
  `SRTP_ASSERT_IMP(a_zero_speed_result, out_valid_r && (speed_out_r == '0), (post_r == '0) && (preload_r == '0), "zero speed result is not all zero")
  `SRTP_ASSERT_IMP(a_moving_has_postscaler, out_valid_r && (speed_out_r != '0), post_r != '0, "moving result has zero postscaler")
  `SRTP_ASSERT_IMP(a_no_overwrite, out_valid_r && !out_if.ready, !emit_load, "pending result overwritten")

endmodule

`default_nettype wire
